[design/srtc_pkg.sv]
// shared types, constants and helpers for the serial rtc shift interface
package srtc_pkg;

	localparam int TIME_BYTES = 7;
	localparam int BYTE_BITS  = 8;
	localparam int CMD_BITS   = 4;
	localparam int COUNT_W    = 6;

	localparam logic [COUNT_W-1:0] CMD_COUNT  = COUNT_W'(CMD_BITS);
	localparam logic [COUNT_W-1:0] DATA_COUNT = COUNT_W'(TIME_BYTES * BYTE_BITS);

	// port_value bit positions
	localparam int PV_DATA_N = 0;
	localparam int PV_CLOCK  = 1;
	localparam int PV_ENABLE = 2;

	// latched time byte order
	localparam int LAT_SECOND  = 0;
	localparam int LAT_WEEKDAY = 1;
	localparam int LAT_YEAR    = 2;
	localparam int LAT_MONTH   = 3;
	localparam int LAT_DAY     = 4;
	localparam int LAT_MINUTE  = 5;
	localparam int LAT_HOUR    = 6;

	// decoded time byte order
	localparam int DEC_WEEKDAY = 0;
	localparam int DEC_YEAR    = 1;
	localparam int DEC_MONTH   = 2;
	localparam int DEC_DAY     = 3;
	localparam int DEC_MINUTE  = 4;
	localparam int DEC_HOUR    = 5;

	// byte number (bits left / 8) at which each written byte completes
	localparam logic [2:0] Q_SECOND = 3'd0;
	localparam logic [2:0] Q_YEAR   = 3'd2;
	localparam logic [2:0] Q_MONTH  = 3'd3;
	localparam logic [2:0] Q_LAST   = 3'(TIME_BYTES - 1);

	localparam logic [7:0] YEAR_PIVOT = 8'd70;
	localparam logic [7:0] CENTURY    = 8'd100;

	typedef enum logic [1:0] {
		MODE_WRITE = 2'd0,
		MODE_READ  = 2'd1,
		MODE_AWAIT = 2'd2
	} mode_t;

	typedef struct packed {
		logic       action;
		logic [2:0] port_value;
		logic [7:0] cur_hour;
		logic [7:0] cur_minute;
		logic [7:0] cur_second;
		logic [7:0] cur_day;
		logic [7:0] cur_month;
		logic [7:0] cur_year;
		logic [7:0] cur_weekday;
	} req_item_t;

	typedef struct packed {
		logic       read_bit;
		logic       time_set_valid;
		logic [7:0] set_hour;
		logic [7:0] set_minute;
		logic [7:0] set_second;
		logic [7:0] set_day;
		logic [7:0] set_month;
		logic [7:0] set_year;
		logic [7:0] set_weekday;
		logic [2:0] command_address;
	} rsp_item_t;

	// bcd byte to binary, hi * 10 + lo, wrapping to 8 bits
	function automatic logic [7:0] bcd_to_bin(input logic [7:0] v);
		logic [7:0] hi;
		hi = {4'd0, v[7:4]};
		return (hi << 3) + (hi << 1) + {4'd0, v[3:0]};
	endfunction

endpackage

[design/srtc_if.sv]
// request and response channel interfaces for the serial rtc shift interface
interface srtc_req_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [2:0] port_value;
	logic [7:0] cur_hour;
	logic [7:0] cur_minute;
	logic [7:0] cur_second;
	logic [7:0] cur_day;
	logic [7:0] cur_month;
	logic [7:0] cur_year;
	logic [7:0] cur_weekday;

	modport source (
		output valid, action, port_value, cur_hour, cur_minute, cur_second,
			cur_day, cur_month, cur_year, cur_weekday,
		input ready
	);
	modport sink (
		input valid, action, port_value, cur_hour, cur_minute, cur_second,
			cur_day, cur_month, cur_year, cur_weekday,
		output ready
	);
endinterface

interface srtc_rsp_if;
	logic       valid;
	logic       ready;
	logic       read_bit;
	logic       time_set_valid;
	logic [7:0] set_hour;
	logic [7:0] set_minute;
	logic [7:0] set_second;
	logic [7:0] set_day;
	logic [7:0] set_month;
	logic [7:0] set_year;
	logic [7:0] set_weekday;
	logic [2:0] command_address;

	modport source (
		output valid, read_bit, time_set_valid, set_hour, set_minute, set_second,
			set_day, set_month, set_year, set_weekday, command_address,
		input ready
	);
	modport sink (
		input valid, read_bit, time_set_valid, set_hour, set_minute, set_second,
			set_day, set_month, set_year, set_weekday, command_address,
		output ready
	);
endinterface

[design/srtc_in_reg.sv]
// input register stage: captures one request transaction per cycle while the stage is empty or advancing
module srtc_in_reg
	import srtc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	srtc_req_if.sink  req,
	input  logic      advance,
	output logic      valid_s1,
	output req_item_t item_s1
);

	logic accept;

	assign req.ready = !valid_s1 || advance;
	assign accept    = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.action      <= req.action;
			item_s1.port_value  <= req.port_value;
			item_s1.cur_hour    <= req.cur_hour;
			item_s1.cur_minute  <= req.cur_minute;
			item_s1.cur_second  <= req.cur_second;
			item_s1.cur_day     <= req.cur_day;
			item_s1.cur_month   <= req.cur_month;
			item_s1.cur_year    <= req.cur_year;
			item_s1.cur_weekday <= req.cur_weekday;
		end
	end

endmodule

[design/srtc_core.sv]
// shift state machine: processes one port access per cycle while advance is high and forms its result
module srtc_core
	import srtc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      advance,
	input  req_item_t item,
	output rsp_item_t result
);

	logic               chip_enabled_q, chip_enabled_d;
	logic               clock_high_q, clock_high_d;
	mode_t              mode_q, mode_d;
	logic [COUNT_W-1:0] bits_left_q, bits_left_d;
	logic [2:0]         address_q, address_d;
	logic [7:0]         receive_q, receive_d;
	logic [7:0]         transmit_q, transmit_d;
	logic [7:0]         latched_q [TIME_BYTES];
	logic [7:0]         latched_d [TIME_BYTES];
	logic [7:0]         decoded_q [TIME_BYTES-1];
	logic [7:0]         decoded_d [TIME_BYTES-1];

	always_comb begin
		logic               en;
		logic               clk_in;
		logic               data;
		logic [COUNT_W-1:0] bits_dec;
		logic [2:0]         k;
		logic [2:0]         q;
		logic [7:0]         tb;
		logic [7:0]         rs;
		logic [7:0]         val;

		en     = item.port_value[PV_ENABLE];
		clk_in = item.port_value[PV_CLOCK];
		data   = !item.port_value[PV_DATA_N];

		chip_enabled_d = chip_enabled_q;
		clock_high_d   = clock_high_q;
		mode_d         = mode_q;
		bits_left_d    = bits_left_q;
		address_d      = address_q;
		receive_d      = receive_q;
		transmit_d     = transmit_q;
		latched_d      = latched_q;
		decoded_d      = decoded_q;
		result         = '0;

		bits_dec = bits_left_q - COUNT_W'(1);
		k        = bits_left_q[5:3];
		q        = bits_dec[5:3];
		tb       = transmit_q;
		rs       = {receive_q[6:0], data};
		val      = bcd_to_bin(rs);

		if (item.action) begin
			// read: reload at each byte boundary, then rotate out lsb first
			if (bits_left_q != '0) begin
				if (bits_left_q[2:0] == 3'd0) begin
					tb = latched_q[k - 3'd1];
				end
				bits_left_d     = bits_dec;
				result.read_bit = tb[0];
				transmit_d      = {tb[0], tb[7:1]};
			end
		end else begin
			priority if (en && !chip_enabled_q) begin
				latched_d[LAT_HOUR]    = item.cur_hour;
				latched_d[LAT_MINUTE]  = item.cur_minute;
				latched_d[LAT_SECOND]  = item.cur_second;
				latched_d[LAT_DAY]     = item.cur_day;
				latched_d[LAT_MONTH]   = item.cur_month;
				latched_d[LAT_YEAR]    = item.cur_year;
				latched_d[LAT_WEEKDAY] = item.cur_weekday;
				bits_left_d            = CMD_COUNT;
				chip_enabled_d         = 1'b1;
			end else if (!en && chip_enabled_q) begin
				chip_enabled_d = 1'b0;
				mode_d         = MODE_AWAIT;
			end else if (!clock_high_q && clk_in) begin
				clock_high_d = 1'b1;
			end else begin
				if (clock_high_q && !clk_in) begin
					clock_high_d = 1'b0;
				end
				if (bits_left_q != '0 && chip_enabled_q && mode_q != MODE_READ) begin
					bits_left_d = bits_dec;
					if (mode_q == MODE_AWAIT) begin
						if (bits_dec != '0) begin
							address_d = {address_q[1:0], data};
						end else begin
							mode_d      = data ? MODE_READ : MODE_WRITE;
							bits_left_d = DATA_COUNT;
						end
					end else begin
						receive_d = rs;
						if (bits_dec[2:0] == 3'd0) begin
							if (q == Q_MONTH) begin
								val = val - 8'd1;
							end else if (q == Q_YEAR && val < YEAR_PIVOT) begin
								val = val + CENTURY;
							end
							if (q != Q_SECOND && q <= Q_LAST) begin
								decoded_d[q - 3'd1] = val;
							end else if (q == Q_SECOND) begin
								result.time_set_valid = 1'b1;
								result.set_hour       = decoded_q[DEC_HOUR];
								result.set_minute     = decoded_q[DEC_MINUTE];
								result.set_second     = val;
								result.set_day        = decoded_q[DEC_DAY];
								result.set_month      = decoded_q[DEC_MONTH];
								result.set_year       = decoded_q[DEC_YEAR];
								result.set_weekday    = decoded_q[DEC_WEEKDAY];
							end
							receive_d = '0;
						end
					end
				end
			end
		end

		result.command_address = address_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chip_enabled_q <= 1'b0;
			clock_high_q   <= 1'b0;
			mode_q         <= MODE_AWAIT;
			bits_left_q    <= '0;
			address_q      <= '0;
			receive_q      <= '0;
			transmit_q     <= '0;
			for (int i = 0; i < TIME_BYTES; i++) begin
				latched_q[i] <= '0;
			end
			for (int i = 0; i < TIME_BYTES - 1; i++) begin
				decoded_q[i] <= '0;
			end
		end else if (advance) begin
			chip_enabled_q <= chip_enabled_d;
			clock_high_q   <= clock_high_d;
			mode_q         <= mode_d;
			bits_left_q    <= bits_left_d;
			address_q      <= address_d;
			receive_q      <= receive_d;
			transmit_q     <= transmit_d;
			latched_q      <= latched_d;
			decoded_q      <= decoded_d;
		end
	end

endmodule

[design/srtc_out_reg.sv]
// result register: holds one response transaction until the sink takes it
module srtc_out_reg
	import srtc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  rsp_item_t  result,
	output logic       free,
	srtc_rsp_if.source rsp
);

	logic      valid_q;
	rsp_item_t item_q;

	assign free = !valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_q <= result;
		end
	end

	assign rsp.valid           = valid_q;
	assign rsp.read_bit        = item_q.read_bit;
	assign rsp.time_set_valid  = item_q.time_set_valid;
	assign rsp.set_hour        = item_q.set_hour;
	assign rsp.set_minute      = item_q.set_minute;
	assign rsp.set_second      = item_q.set_second;
	assign rsp.set_day         = item_q.set_day;
	assign rsp.set_month       = item_q.set_month;
	assign rsp.set_year        = item_q.set_year;
	assign rsp.set_weekday     = item_q.set_weekday;
	assign rsp.command_address = item_q.command_address;

endmodule

[design/serial_rtc_shift_interface.sv]
// top level of the serial rtc shift interface
// Each request transaction is one port access (write of enable, clock and
// inverted data, or a read of the next serial bit) and gives exactly one
// response transaction. The block sustains one transaction per cycle while
// the response side takes its results: a request is captured in the input
// register, the shift state and the result are computed from it when it
// advances, and the result lands in the result register, where the response
// is presented until it is taken. The result register lets the next request
// enter while a response still waits; the only stalls come from the response
// side holding ready low.
module serial_rtc_shift_interface
	import srtc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	srtc_req_if.sink   req,
	srtc_rsp_if.source rsp
);

	logic      valid_s1;
	req_item_t item_s1;
	rsp_item_t result;
	logic      free;
	logic      advance;

	assign advance = valid_s1 && free;

	srtc_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	srtc_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.result  (result)
	);

	srtc_out_reg u_out_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance),
		.result (result),
		.free   (free),
		.rsp    (rsp)
	);

	// an empty result register never blocks the request side
	a_ready_when_empty: assert property (
		@(posedge clk) disable iff (!arst_n) !rsp.valid |-> req.ready
	) else $error("request stalled with empty result register");

	// every processed request shows up as a response next cycle
	a_result_follows: assert property (
		@(posedge clk) disable iff (!arst_n) advance |=> rsp.valid
	) else $error("processed request produced no response");

	// a set-time result comes from a write, never from a read
	a_set_time_sane: assert property (
		@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.time_set_valid |-> !rsp.read_bit
	) else $error("malformed set-time response");

endmodule

[sim/srtc_result_checker.sv]
// checker: predicts every port access of the serial rtc shift interface and compares responses
`timescale 1ns / 1ps

module srtc_result_checker
	import srtc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	srtc_req_if  req,
	srtc_rsp_if  rsp,
	output int   mismatches,
	output int   outstanding
);

	rsp_item_t  expected_results[$];

	// predicted shift state
	logic       chip_on;
	logic       clock_up;
	mode_t      mode;
	logic [5:0] bits_left;
	logic [2:0] addr_bits;
	logic [7:0] rx_byte;
	logic [7:0] tx_byte;
	logic [7:0] snap_time [TIME_BYTES];
	logic [7:0] set_fields [TIME_BYTES-1];

	task automatic report_mismatch(input string what);
		$display("%0t ns: mismatch: %s", $time, what);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [7:0] got,
			input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	task automatic predict_port_access(input req_item_t it, output rsp_item_t res);
		logic       en;
		logic       ck;
		logic       din;
		logic [2:0] q;
		logic [7:0] val;
		res = '0;
		if (it.action) begin
			if (bits_left != 6'd0) begin
				// byte boundary: next latched byte goes out
				if (bits_left[2:0] == 3'd0)
					tx_byte = snap_time[bits_left[5:3] - 3'd1];
				bits_left = bits_left - 6'd1;
				res.read_bit = tx_byte[0];
				tx_byte = {tx_byte[0], tx_byte[7:1]};
			end
		end else begin
			en  = it.port_value[PV_ENABLE];
			ck  = it.port_value[PV_CLOCK];
			din = ~it.port_value[PV_DATA_N];
			if (en && !chip_on) begin
				snap_time[LAT_HOUR]    = it.cur_hour;
				snap_time[LAT_MINUTE]  = it.cur_minute;
				snap_time[LAT_SECOND]  = it.cur_second;
				snap_time[LAT_DAY]     = it.cur_day;
				snap_time[LAT_MONTH]   = it.cur_month;
				snap_time[LAT_YEAR]    = it.cur_year;
				snap_time[LAT_WEEKDAY] = it.cur_weekday;
				bits_left = CMD_COUNT;
				chip_on = 1'b1;
			end else if (!en && chip_on) begin
				chip_on = 1'b0;
				mode = MODE_AWAIT;
			end else if (!clock_up && ck) begin
				clock_up = 1'b1;
			end else begin
				if (clock_up && !ck)
					clock_up = 1'b0;
				if (bits_left != 6'd0 && chip_on && mode != MODE_READ) begin
					bits_left = bits_left - 6'd1;
					if (mode == MODE_AWAIT) begin
						if (bits_left != 6'd0) begin
							addr_bits = {addr_bits[1:0], din};
						end else begin
							mode = din ? MODE_READ : MODE_WRITE;
							bits_left = DATA_COUNT;
						end
					end else begin
						rx_byte = {rx_byte[6:0], din};
						if (bits_left[2:0] == 3'd0) begin
							q = bits_left[5:3];
							val = {4'd0, rx_byte[7:4]} * 8'd10 + {4'd0, rx_byte[3:0]};
							if (q == Q_MONTH)
								val = val - 8'd1;
							else if (q == Q_YEAR && val < YEAR_PIVOT)
								val = val + CENTURY;
							if (q == Q_SECOND) begin
								res.time_set_valid = 1'b1;
								res.set_hour    = set_fields[DEC_HOUR];
								res.set_minute  = set_fields[DEC_MINUTE];
								res.set_second  = val;
								res.set_day     = set_fields[DEC_DAY];
								res.set_month   = set_fields[DEC_MONTH];
								res.set_year    = set_fields[DEC_YEAR];
								res.set_weekday = set_fields[DEC_WEEKDAY];
							end else begin
								set_fields[q - 3'd1] = val;
							end
							rx_byte = 8'd0;
						end
					end
				end
			end
		end
		res.command_address = addr_bits;
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_item_t want;
		req_item_t item;
		if (!arst_n) begin
			chip_on   = 1'b0;
			clock_up  = 1'b0;
			mode      = MODE_AWAIT;
			bits_left = 6'd0;
			addr_bits = 3'd0;
			rx_byte   = 8'd0;
			tx_byte   = 8'd0;
			for (int i = 0; i < TIME_BYTES; i++)
				snap_time[i] = 8'd0;
			for (int i = 0; i < TIME_BYTES - 1; i++)
				set_fields[i] = 8'd0;
			expected_results.delete();
			mismatches = 0;
		end else begin
			// responses belong to earlier requests, so retire before adding
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("response transaction with no request outstanding");
				end else begin
					want = expected_results.pop_front();
					check_field("read_bit", {7'd0, rsp.read_bit}, {7'd0, want.read_bit});
					check_field("time_set_valid", {7'd0, rsp.time_set_valid},
						{7'd0, want.time_set_valid});
					check_field("set_hour", rsp.set_hour, want.set_hour);
					check_field("set_minute", rsp.set_minute, want.set_minute);
					check_field("set_second", rsp.set_second, want.set_second);
					check_field("set_day", rsp.set_day, want.set_day);
					check_field("set_month", rsp.set_month, want.set_month);
					check_field("set_year", rsp.set_year, want.set_year);
					check_field("set_weekday", rsp.set_weekday, want.set_weekday);
					check_field("command_address", {5'd0, rsp.command_address},
						{5'd0, want.command_address});
				end
			end
			if (req.valid && req.ready) begin
				item = '{req.action, req.port_value, req.cur_hour, req.cur_minute,
					req.cur_second, req.cur_day, req.cur_month, req.cur_year,
					req.cur_weekday};
				predict_port_access(item, want);
				expected_results.push_back(want);
			end
		end
		outstanding = expected_results.size();
	end

endmodule

[sim/serial_rtc_shift_interface_tb.sv]
// testbench top: drives port accesses into the serial rtc shift interface and gives the verdict
`timescale 1ns / 1ps

module serial_rtc_shift_interface_tb;
	import srtc_pkg::*;

	localparam int ITEM_TARGET  = 1875;
	localparam int CALM_TAIL    = 200;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 10;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   outstanding;
	int   sent = 0;
	int   cycle_count = 0;
	bit   calm = 1'b0;
	bit   clk_up = 1'b0;

	srtc_req_if req_ch();
	srtc_rsp_if rsp_ch();

	serial_rtc_shift_interface dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	srtc_result_checker u_results (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// response side stalls in short random bursts
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && !calm && $urandom_range(0, 7) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			rsp_ch.ready <= arst_n;
		end
	end

	function automatic req_item_t random_item();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[$bits(req_item_t)-1:0];
	endfunction

	function automatic logic [7:0] time_byte();
		int r;
		r = $urandom_range(0, 19);
		if (r < 3)
			return 8'h00;
		if (r < 6)
			return 8'($urandom);
		r = $urandom_range(0, 99);
		return {4'(r / 10), 4'(r % 10)};
	endfunction

	task automatic send_item(input req_item_t it);
		req_ch.valid       <= 1'b1;
		req_ch.action      <= it.action;
		req_ch.port_value  <= it.port_value;
		req_ch.cur_hour    <= it.cur_hour;
		req_ch.cur_minute  <= it.cur_minute;
		req_ch.cur_second  <= it.cur_second;
		req_ch.cur_day     <= it.cur_day;
		req_ch.cur_month   <= it.cur_month;
		req_ch.cur_year    <= it.cur_year;
		req_ch.cur_weekday <= it.cur_weekday;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		sent++;
		if (sent >= ITEM_TARGET - CALM_TAIL)
			calm = 1'b1;
		if (!calm && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic port_write(input logic [2:0] pv);
		req_item_t it;
		it = random_item();
		it.action = 1'b0;
		it.port_value = pv;
		send_item(it);
	endtask

	task automatic port_read();
		req_item_t it;
		it = random_item();
		it.action = 1'b1;
		send_item(it);
	endtask

	task automatic latch_time(input logic [2:0] pv, input logic [7:0] v);
		req_item_t it;
		it = random_item();
		it.action = 1'b0;
		it.port_value = pv;
		it.cur_hour = v;
		it.cur_minute = v;
		it.cur_second = v;
		it.cur_day = v;
		it.cur_month = v;
		it.cur_year = v;
		it.cur_weekday = v;
		send_item(it);
	endtask

	// one data step with the chip enabled; clk_up tracks the serial clock line
	task automatic shift_bit(input logic b);
		logic dn;
		dn = ~b;
		if (clk_up) begin
			if ($urandom_range(0, 1)) begin
				port_write({1'b1, 1'b1, dn});
			end else begin
				port_write({1'b1, 1'b0, dn});
				clk_up = 1'b0;
			end
		end else begin
			case ($urandom_range(0, 9))
				0: port_write({1'b1, 1'b0, dn});
				1: begin
					port_write({1'b1, 1'b1, 1'($urandom)});
					port_write({1'b1, 1'b1, dn});
					clk_up = 1'b1;
				end
				default: begin
					port_write({1'b1, 1'b1, 1'($urandom)});
					port_write({1'b1, 1'b0, dn});
				end
			endcase
		end
	endtask

	// disable, settle the clock low, enable, command, then cut data steps
	task automatic run_session(input logic rd, input int cut);
		logic [2:0] addr;
		logic [7:0] tbyte;
		port_write({1'b0, 1'($urandom), 1'($urandom)});
		port_write({1'b0, 1'b0, 1'($urandom)});
		port_write({1'b1, 1'($urandom), 1'($urandom)});
		clk_up = 1'b0;
		addr = 3'($urandom);
		for (int i = 2; i >= 0; i--)
			shift_bit(addr[i]);
		shift_bit(rd);
		for (int i = 0; i < cut; i++) begin
			if (rd) begin
				// stray enabled writes in read mode must not disturb the shift
				if ($urandom_range(0, 9) == 0)
					port_write({1'b1, 2'($urandom)});
				port_read();
			end else begin
				if (i % 8 == 0)
					tbyte = time_byte();
				shift_bit(tbyte[7 - i % 8]);
			end
		end
	endtask

	initial begin
		int pick;
		arst_n             <= 1'b0;
		req_ch.valid       <= 1'b0;
		req_ch.action      <= 1'b0;
		req_ch.port_value  <= 3'd0;
		req_ch.cur_hour    <= 8'd0;
		req_ch.cur_minute  <= 8'd0;
		req_ch.cur_second  <= 8'd0;
		req_ch.cur_day     <= 8'd0;
		req_ch.cur_month   <= 8'd0;
		req_ch.cur_year    <= 8'd0;
		req_ch.cur_weekday <= 8'd0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// read with nothing left to shift, clocking a disabled chip
		port_read();
		port_write(3'b010);
		port_write(3'b000);
		// all-ones time, command address 7 in read mode, reads across a byte
		latch_time(3'b111, 8'hFF);
		repeat (4) port_write(3'b100);
		repeat (10) port_read();
		port_write(3'b101);
		port_write(3'b000);
		// all-zero time, command address 0 in write mode
		latch_time(3'b100, 8'h00);
		repeat (4) port_write(3'b101);

		while (sent < ITEM_TARGET) begin
			pick = $urandom_range(0, 19);
			if (pick < 9)
				run_session(1'b0, TIME_BYTES * BYTE_BITS);
			else if (pick < 14)
				run_session(1'b1, TIME_BYTES * BYTE_BITS + $urandom_range(0, 4));
			else if (pick < 17)
				run_session(1'($urandom), $urandom_range(0, TIME_BYTES * BYTE_BITS - 1));
			else
				repeat ($urandom_range(1, 20)) send_item(random_item());
			if ($urandom_range(0, 1))
				port_write({1'b0, 2'($urandom)});
		end
		req_ch.valid <= 1'b0;

		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
